// File: sv/tbri_pkg.sv
`default_nettype none
package tbri_pkg;
    localparam int unsigned CAPACITY_DEF = 32;
    localparam int unsigned QDEPTH = 2;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_REMOVE = 2'd1,
        K_QUERY  = 2'd2,
        K_EXPIRE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] time_a;
        logic [31:0] time_b;
        logic [31:0] block_id;
    } t_in;

    typedef struct packed {
        logic        status;
        logic        has_id;
        logic [31:0] block_out;
        logic        last;
        logic [5:0]  bucket_count;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_SEARCH,
        S_EMIT,
        S_COUNT,
        S_DONE
    } t_state;

    // ordered compare on (time, id)
    function automatic logic pair_less(input logic [31:0] ta, input logic [31:0] ia,
                                       input logic [31:0] tb, input logic [31:0] ib);
        pair_less = (ta < tb) || ((ta == tb) && (ia < ib));
    endfunction
endpackage
`default_nettype wire

// File: sv/time_bucket_range_index.sv
// Channel  | Ports                          | Handshake
// command  | i_start, o_busy, i_cmd         | taken when i_start && !o_busy
// result   | o_valid, o_res                 | one-cycle strobe per result, no stall
// Insert/remove on an idle engine: queue, pop, a scan of all CAPACITY slots, then the
// pairwise recount, then the result.
// Query/expire: pop, the same recount, then one search pass per id found plus one
// final empty pass; ids leave one pass late so the final one can carry last.
// Two items queue in front of the table engine; busy reflects a full queue.
// The receiver cannot stall. Reset (synchronous, active low) empties table and queue.
`default_nettype none
module time_bucket_range_index #(
    parameter int unsigned CAPACITY = tbri_pkg::CAPACITY_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire tbri_pkg::t_in i_cmd,
    output logic               o_busy,
    output logic               o_valid,
    output tbri_pkg::t_out     o_res
);
    logic          full, avail, pop, idle;
    tbri_pkg::t_in item;

    assign o_busy = full;

    tbri_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_start), .i_item(i_cmd),
        .o_full(full), .i_pop(pop), .o_avail(avail), .o_item(item)
    );

    tbri_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(avail), .i_item(item),
        .o_pop(pop), .o_idle(idle), .o_valid(o_valid), .o_res(o_res)
    );

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.status |-> o_res.last && !o_res.has_id)
        else $error("status set on non-final result");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.bucket_count <= 6'(CAPACITY))
        else $error("bucket count out of range");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> idle && avail)
        else $error("pop while engine busy");
endmodule
`default_nettype wire

// File: sv/tbri_front.sv
`default_nettype none
// Accepts items into a small queue; back end pops them.
module tbri_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tbri_pkg::t_in i_item,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_avail,
    output tbri_pkg::t_in      o_item
);
    tbri_pkg::t_in r_q [tbri_pkg::QDEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'(tbri_pkg::QDEPTH));
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && o_avail) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && o_avail);
        end
    end
endmodule
`default_nettype wire

// File: sv/tbri_back.sv
`default_nettype none
// Table engine. Insert/remove: one scan for match/free slot, then a recount.
// Query/expire: recount of the surviving entries first, then one search pass per
// id; each id is held for one pass so the final one can carry last.
module tbri_back #(
    parameter int unsigned CAPACITY = tbri_pkg::CAPACITY_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_avail,
    input  wire tbri_pkg::t_in i_item,
    output logic               o_pop,
    output logic               o_idle,
    output logic               o_valid,
    output tbri_pkg::t_out     o_res
);
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [CAPACITY-1:0] r_valid, n_valid;
    logic [31:0]         r_time [CAPACITY];
    logic [31:0]         r_id   [CAPACITY];

    tbri_pkg::t_state r_st, n_st;
    tbri_pkg::t_in    r_op, n_op;
    logic [IW-1:0]    r_i, n_i;          // scan index
    logic [CAPACITY-1:0] r_done, n_done; // already emitted this op
    logic             r_fnd, n_fnd;
    logic [IW-1:0]    r_fi, n_fi;
    logic [31:0]      r_bt, n_bt;        // best pair of the current search pass
    logic [31:0]      r_bid, n_bid;
    logic             r_fre, n_fre;
    logic [IW-1:0]    r_fr, n_fr;
    logic             r_stat, n_stat;
    logic             r_pend, n_pend;    // held id waiting for the next pass
    logic [31:0]      r_pid, n_pid;
    logic [IW-1:0]    r_j, n_j;          // count inner index
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_seen, n_seen;
    logic             r_ov, n_ov;
    tbri_pkg::t_out   r_res, n_res;
    logic             n_wr;

    logic [31:0] ti, ii, tj;
    logic        vi, mt, last_i, exp_op, kept_i, kept_j;
    assign ti = r_time[r_i];
    assign ii = r_id[r_i];
    assign tj = r_time[r_j];
    assign vi = r_valid[r_i] && !r_done[r_i];
    assign last_i = (r_i == IW'(CAPACITY - 1));
    assign exp_op = (r_op.kind == tbri_pkg::K_EXPIRE);
    // expiry counts only the entries that survive it
    assign kept_i = r_valid[r_i] && !(exp_op && (ti < r_op.time_a));
    assign kept_j = r_valid[r_j] && !(exp_op && (tj < r_op.time_a));
    always_comb begin
        if (r_op.kind == tbri_pkg::K_QUERY) begin
            mt = vi && (ti >= r_op.time_a) && (ti <= r_op.time_b);
        end else begin
            mt = vi && (ti < r_op.time_a);
        end
    end

    assign o_pop   = (r_st == tbri_pkg::S_IDLE) && i_avail;
    assign o_idle  = (r_st == tbri_pkg::S_IDLE);
    assign o_valid = r_ov;
    assign o_res   = r_res;

    always_comb begin
        n_st = r_st; n_op = r_op; n_i = r_i; n_done = r_done; n_fnd = r_fnd;
        n_fi = r_fi; n_bt = r_bt; n_bid = r_bid; n_fre = r_fre; n_fr = r_fr;
        n_stat = r_stat; n_pend = r_pend; n_pid = r_pid; n_j = r_j; n_cnt = r_cnt;
        n_seen = r_seen; n_valid = r_valid; n_ov = 1'b0; n_res = r_res; n_wr = 1'b0;
        case (r_st)
            tbri_pkg::S_IDLE: begin
                if (i_avail) begin
                    n_op = i_item; n_i = '0; n_done = '0; n_fnd = 1'b0; n_fre = 1'b0;
                    n_stat = 1'b0; n_pend = 1'b0; n_pid = '0;
                    n_j = '0; n_cnt = '0; n_seen = 1'b0;
                    n_st = (i_item.kind == tbri_pkg::K_INSERT ||
                            i_item.kind == tbri_pkg::K_REMOVE) ?
                           tbri_pkg::S_UPDATE : tbri_pkg::S_COUNT;
                end
            end
            tbri_pkg::S_UPDATE: begin
                if (r_valid[r_i]) begin
                    if (ti == r_op.time_a && ii == r_op.block_id) begin
                        n_fnd = 1'b1; n_fi = r_i;
                    end
                end else if (!r_fre) begin
                    n_fre = 1'b1; n_fr = r_i;
                end
                n_i = r_i + IW'(1);
                if (last_i) begin
                    n_i = '0;
                    if (r_op.kind == tbri_pkg::K_INSERT) begin
                        if (!n_fnd) begin
                            if (n_fre) begin
                                n_valid[n_fr] = 1'b1; n_wr = 1'b1;
                            end else begin
                                n_stat = 1'b1;
                            end
                        end
                    end else if (n_fnd) begin
                        n_valid[n_fi] = 1'b0;
                    end
                    n_st = tbri_pkg::S_COUNT;
                end
            end
            tbri_pkg::S_COUNT: begin
                // slot i counts if kept and no earlier kept slot j has same time
                if (r_j == r_i) begin
                    if (kept_i && !r_seen) n_cnt = r_cnt + CW'(1);
                    n_seen = 1'b0; n_j = '0;
                    n_i = r_i + IW'(1);
                    if (last_i) begin
                        n_i = '0;
                        n_fnd = 1'b0;
                        n_st = (r_op.kind == tbri_pkg::K_INSERT ||
                                r_op.kind == tbri_pkg::K_REMOVE) ?
                               tbri_pkg::S_DONE : tbri_pkg::S_SEARCH;
                    end
                end else begin
                    if (kept_j && tj == ti) n_seen = 1'b1;
                    n_j = r_j + IW'(1);
                end
            end
            tbri_pkg::S_SEARCH: begin
                // find minimal matching pair not yet emitted
                if (mt && (!r_fnd || tbri_pkg::pair_less(ti, ii, r_bt, r_bid))) begin
                    n_fnd = 1'b1; n_fi = r_i; n_bt = ti; n_bid = ii;
                end
                n_i = r_i + IW'(1);
                if (last_i) begin
                    n_i = '0;
                    n_st = tbri_pkg::S_EMIT;
                end
            end
            tbri_pkg::S_EMIT: begin
                if (r_fnd) begin
                    if (r_pend) begin
                        n_ov = 1'b1;
                        n_res = '{status: 1'b0, has_id: 1'b1, block_out: r_pid,
                                  last: 1'b0, bucket_count: 6'(r_cnt)};
                    end
                    n_pend = 1'b1; n_pid = r_bid;
                    n_done[r_fi] = 1'b1;
                    if (exp_op) begin
                        n_valid[r_fi] = 1'b0;
                    end
                    n_fnd = 1'b0;
                    n_st = tbri_pkg::S_SEARCH;
                end else begin
                    n_st = tbri_pkg::S_DONE;
                end
            end
            tbri_pkg::S_DONE: begin
                n_ov = 1'b1;
                n_res = '{status: r_stat, has_id: r_pend, block_out: r_pid,
                          last: 1'b1, bucket_count: 6'(r_cnt)};
                n_st = tbri_pkg::S_IDLE;
            end
            default: n_st = tbri_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_time[n_fr] <= r_op.time_a;
            r_id[n_fr]   <= r_op.block_id;
        end
        r_op <= n_op; r_i <= n_i; r_done <= n_done; r_fnd <= n_fnd; r_fi <= n_fi;
        r_bt <= n_bt; r_bid <= n_bid;
        r_fre <= n_fre; r_fr <= n_fr; r_stat <= n_stat;
        r_pend <= n_pend; r_pid <= n_pid; r_j <= n_j; r_cnt <= n_cnt;
        r_seen <= n_seen; r_res <= n_res;
        if (!i_rst_n) begin
            r_st <= tbri_pkg::S_IDLE;
            r_valid <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_valid <= n_valid;
            r_ov <= n_ov;
        end
    end
endmodule
`default_nettype wire
